FILE: design/rhd_pkg.sv
`default_nettype none

package rhd_pkg;

    // Request codes carried by an input item.
    localparam logic [1:0] REQ_INIT = 2'd0;
    localparam logic [1:0] REQ_STEP = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;
    // The remaining code changes nothing and reports like a read with no data.
    localparam logic [1:0] REQ_NOP  = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SEGMENTS  = 3'd0;
    localparam logic [2:0] CFG_IFACE     = 3'd1;
    localparam logic [2:0] CFG_GAIN_IN   = 3'd2;
    localparam logic [2:0] CFG_GAIN_OUT  = 3'd3;
    localparam logic [2:0] CFG_RADIUS    = 3'd4;
    localparam logic [2:0] CFG_W_INNER   = 3'd5;
    localparam logic [2:0] CFG_W_OUTER   = 3'd6;
    localparam logic [2:0] CFG_THRESHOLD = 3'd7;

    // Temperatures in Q12.20 kelvin.
    localparam logic [31:0] TEMP_INIT = 32'h12C0_0000;  // 300 K
    localparam logic [31:0] TEMP_HOT  = 32'h5DC0_0000;  // 1500 K
    localparam logic [31:0] TEMP_AMB  = 32'h12A0_0000;  // 298 K

    // Curvature divider widths: numerator magnitude and radius divisor.
    localparam int NUM_W = 51;
    localparam int DEN_W = 17;

    typedef struct packed {
        logic [1:0] req_type;
        logic [8:0] node_index;
    } req_t;

    typedef struct packed {
        logic [31:0] max_change;
        logic        converged;
        logic [31:0] inner_face_temp;
        logic [31:0] interface_temp;
        logic [31:0] outer_face_temp;
        logic [31:0] read_temp;
        logic [31:0] steps_done;
    } res_t;

endpackage

`default_nettype wire

FILE: design/rhd_div.sv
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module rhd_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [rhd_pkg::NUM_W-1:0]  num,
    input  wire logic [rhd_pkg::DEN_W-1:0]  den,
    output logic                            done,
    output logic [rhd_pkg::NUM_W-1:0]       quo
);

    localparam int NW = rhd_pkg::NUM_W;
    localparam int DW = rhd_pkg::DEN_W;
    localparam int CW = $clog2(NW);
    localparam logic [CW-1:0] LAST_CNT = CW'(NW - 1);

    logic          run_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW:0]   rem_reg;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] den_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;

    // Trial subtraction of the divisor from the shifted remainder.
    always_comb
    begin
        trial = {rem_reg[DW-1:0], quo_reg[NW-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = trial >= {1'b0, den_reg};
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                if (cnt_reg == LAST_CNT)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? diff : trial;
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

FILE: design/radial_heat_diffusion_step.sv
// Step request: a priming read, then per node a read, a capture and a multiply, and for an
// interior node a second multiply and a wait on the bit-serial curvature divider, then the write; then readout.
// Init request: profile fill then readout; read request: readout only.
// One item at a time; busy stays high until the result strobe, which cannot be held off.
// After reset the profile memory is filled with 300 K while busy.
`default_nettype none

module radial_heat_diffusion_step #(
    parameter int MAX_NODES = 512
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire rhd_pkg::req_t req,
    output logic               done,
    output rhd_pkg::res_t      result,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [31:0]   cfg_data
);

    localparam int IW = $clog2(MAX_NODES);
    localparam logic [IW-1:0] LAST_ADDR = IW'(MAX_NODES - 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FILL  = 4'd1;
    localparam logic [3:0] ST_PRIME = 4'd2;
    localparam logic [3:0] ST_READ  = 4'd3;
    localparam logic [3:0] ST_CAP   = 4'd4;
    localparam logic [3:0] ST_MUL1  = 4'd5;
    localparam logic [3:0] ST_MUL2  = 4'd6;
    localparam logic [3:0] ST_DIVGO = 4'd7;
    localparam logic [3:0] ST_DIVW  = 4'd8;
    localparam logic [3:0] ST_WRITE = 4'd9;
    localparam logic [3:0] ST_RD0   = 4'd10;
    localparam logic [3:0] ST_RDB   = 4'd11;
    localparam logic [3:0] ST_RDN   = 4'd12;
    localparam logic [3:0] ST_RDX   = 4'd13;
    localparam logic [3:0] ST_FIN   = 4'd14;

    // Configuration registers.
    logic [8:0]  seg_reg;
    logic [8:0]  iface_reg;
    logic [14:0] gin_reg;
    logic [14:0] gout_reg;
    logic [15:0] radius_reg;
    logic [15:0] w_in_reg;
    logic [15:0] w_out_reg;
    logic [31:0] thr_reg;

    // Sequencer state.
    logic [3:0]    state_reg;
    logic [IW-1:0] i_reg;
    logic          init_pend_reg;
    logic          done_reg;
    logic [31:0]   steps_reg;

    // Datapath registers.
    rhd_pkg::req_t req_reg;
    rhd_pkg::res_t res_reg;
    logic [31:0]   tl_reg;
    logic [31:0]   ti_reg;
    logic [31:0]   tr_reg;
    logic signed [50:0] mul_reg;
    logic signed [50:0] lap_reg;
    logic          neg_reg;
    logic [31:0]   maxc_reg;
    logic [31:0]   inner_q_reg;
    logic [31:0]   iface_q_reg;
    logic [31:0]   outer_q_reg;

    // Profile memory.
    logic [31:0]   mem [MAX_NODES];
    logic [31:0]   rd_q_reg;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [31:0]   wr_data;

    // Clamped geometry and node classification.
    logic [15:0]   seg_w;
    logic [15:0]   n_w;
    logic [15:0]   bi_w;
    logic [15:0]   b_w;
    logic [15:0]   idx_w;
    logic [IW-1:0] n_idx;
    logic [IW-1:0] b_idx;
    logic [IW-1:0] idx_addr;
    logic          idx_ok;
    logic          at_first;
    logic          at_last;
    logic          at_iface;
    logic          interior;
    logic [14:0]   gain;
    logic [16:0]   radius_div;

    // Shared multiplier and node update.
    logic signed [16:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [50:0] mul_p;
    logic [50:0]        mag;
    logic               div_start;
    logic [rhd_pkg::NUM_W-1:0] div_num;
    logic               div_done;
    logic [rhd_pkg::NUM_W-1:0] div_quo;
    logic [31:0]        blend_t;
    logic signed [52:0] blend_s;
    logic signed [51:0] curv;
    logic signed [52:0] int_s;
    logic signed [37:0] int_v;
    logic [36:0]        if_s;
    logic [31:0]        new_val;
    logic [31:0]        dv;

    always_comb
    begin
        seg_w = 16'(seg_reg);
        if (seg_w < 16'd2)
            n_w = 16'd2;
        else if (seg_w > 16'(MAX_NODES - 1))
            n_w = 16'(MAX_NODES - 1);
        else
            n_w = seg_w;
        bi_w = 16'(iface_reg);
        if (bi_w < 16'd1)
            b_w = 16'd1;
        else if (bi_w > n_w - 16'd1)
            b_w = n_w - 16'd1;
        else
            b_w = bi_w;
        n_idx    = n_w[IW-1:0];
        b_idx    = b_w[IW-1:0];
        idx_w    = 16'(req_reg.node_index);
        idx_addr = idx_w[IW-1:0];
        idx_ok   = idx_w < 16'(MAX_NODES);

        at_first   = i_reg == '0;
        at_last    = i_reg == n_idx;
        at_iface   = i_reg == b_idx;
        interior   = !at_first && !at_last && !at_iface;
        gain       = (i_reg < b_idx) ? gin_reg : gout_reg;
        radius_div = {1'b0, radius_reg} + (17'(i_reg) << 4);
    end

    // Multiplier operands: blend weight, Laplacian gain, then curvature gain.
    always_comb
    begin
        if (state_reg == ST_MUL2)
        begin
            mul_a = $signed({2'b0, gain});
            mul_b = $signed({2'b0, tr_reg}) - $signed({2'b0, tl_reg});
        end
        else if (at_first)
        begin
            mul_a = $signed({1'b0, w_in_reg});
            mul_b = $signed({2'b0, rhd_pkg::TEMP_HOT}) - $signed({2'b0, tr_reg});
        end
        else if (at_last)
        begin
            mul_a = $signed({1'b0, w_out_reg});
            mul_b = $signed({2'b0, rhd_pkg::TEMP_AMB}) - $signed({2'b0, tl_reg});
        end
        else
        begin
            mul_a = $signed({2'b0, gain});
            mul_b = $signed({2'b0, tl_reg}) + $signed({2'b0, tr_reg})
                  - $signed({1'b0, ti_reg, 1'b0});
        end
        mul_p = mul_a * mul_b;
    end

    // Curvature numerator magnitude, scaled by 8.
    always_comb
    begin
        mag       = mul_reg[50] ? 51'(-mul_reg) : 51'(mul_reg);
        div_num   = mag << 3;
        div_start = state_reg == ST_DIVGO;
    end

    rhd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (radius_div),
        .done  (div_done),
        .quo   (div_quo)
    );

    // New node value for the node kind at hand.
    always_comb
    begin
        blend_t = at_first ? tr_reg : tl_reg;
        blend_s = $signed({5'b0, blend_t, 16'b0}) + $signed({{2{mul_reg[50]}}, mul_reg})
                + 53'sd32768;
        curv    = neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
        int_s   = $signed({{2{lap_reg[50]}}, lap_reg}) + $signed({curv[51], curv})
                + 53'sd32768;
        int_v   = $signed({6'b0, ti_reg}) + $signed({int_s[52], int_s[52:16]});
        if_s    = {1'b0, tl_reg, 4'b0} - {5'b0, tl_reg} + {5'b0, tr_reg} + 37'd8;
        if (at_first || at_last)
            new_val = blend_s[47:16];
        else if (at_iface)
            new_val = if_s[35:4];
        else if (int_v[37])
            new_val = '0;
        else if (int_v[36:32] != '0)
            new_val = '1;
        else
            new_val = int_v[31:0];
        dv = (new_val > ti_reg) ? new_val - ti_reg : ti_reg - new_val;
    end

    // Memory port selection.
    always_comb
    begin
        unique case (state_reg)
            ST_READ: rd_addr = i_reg + 1'b1;
            ST_RDB:  rd_addr = b_idx;
            ST_RDN:  rd_addr = n_idx;
            ST_RDX:  rd_addr = idx_addr;
            default: rd_addr = '0;
        endcase
        wr_en   = (state_reg == ST_FILL) || (state_reg == ST_WRITE);
        wr_data = (state_reg == ST_FILL) ? rhd_pkg::TEMP_INIT : new_val;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[i_reg] <= wr_data;
        rd_q_reg <= mem[rd_addr];
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg    <= 9'd300;
            iface_reg  <= 9'd100;
            gin_reg    <= 15'd10518;
            gout_reg   <= 15'd17476;
            radius_reg <= 16'd1600;
            w_in_reg   <= 16'd2621;
            w_out_reg  <= 16'd806;
            thr_reg    <= 32'd10;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rhd_pkg::CFG_SEGMENTS:  seg_reg    <= cfg_data[8:0];
                rhd_pkg::CFG_IFACE:     iface_reg  <= cfg_data[8:0];
                rhd_pkg::CFG_GAIN_IN:   gin_reg    <= cfg_data[14:0];
                rhd_pkg::CFG_GAIN_OUT:  gout_reg   <= cfg_data[14:0];
                rhd_pkg::CFG_RADIUS:    radius_reg <= cfg_data[15:0];
                rhd_pkg::CFG_W_INNER:   w_in_reg   <= cfg_data[15:0];
                rhd_pkg::CFG_W_OUTER:   w_out_reg  <= cfg_data[15:0];
                rhd_pkg::CFG_THRESHOLD: thr_reg    <= cfg_data;
            endcase
        end
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            i_reg         <= '0;
            init_pend_reg <= 1'b0;
            done_reg      <= 1'b0;
            steps_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        i_reg <= '0;
                        if (req.req_type == rhd_pkg::REQ_INIT)
                        begin
                            state_reg     <= ST_FILL;
                            init_pend_reg <= 1'b1;
                            steps_reg     <= '0;
                        end
                        else if (req.req_type == rhd_pkg::REQ_STEP)
                            state_reg <= ST_PRIME;
                        else
                            state_reg <= ST_RD0;
                    end
                end
                ST_FILL:
                begin
                    if (i_reg == LAST_ADDR)
                    begin
                        i_reg         <= '0;
                        init_pend_reg <= 1'b0;
                        state_reg     <= init_pend_reg ? ST_RD0 : ST_IDLE;
                    end
                    else
                        i_reg <= i_reg + 1'b1;
                end
                ST_PRIME: state_reg <= ST_READ;
                ST_READ:  state_reg <= ST_CAP;
                ST_CAP:   state_reg <= ST_MUL1;
                ST_MUL1:  state_reg <= interior ? ST_MUL2 : ST_WRITE;
                ST_MUL2:  state_reg <= ST_DIVGO;
                ST_DIVGO: state_reg <= ST_DIVW;
                ST_DIVW:
                begin
                    if (div_done)
                        state_reg <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    if (at_last)
                    begin
                        state_reg <= ST_RD0;
                        steps_reg <= steps_reg + 1'b1;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_READ;
                    end
                end
                ST_RD0: state_reg <= ST_RDB;
                ST_RDB: state_reg <= ST_RDN;
                ST_RDN: state_reg <= ST_RDX;
                ST_RDX: state_reg <= ST_FIN;
                ST_FIN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Node window, products, change tracking and result assembly.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            req_reg  <= req;
            maxc_reg <= '0;
        end
        if (state_reg == ST_PRIME)
            ti_reg <= rd_q_reg;
        if (state_reg == ST_CAP)
            tr_reg <= rd_q_reg;
        if (state_reg == ST_MUL1 || state_reg == ST_MUL2)
            mul_reg <= mul_p;
        if (state_reg == ST_MUL2)
            lap_reg <= mul_reg;
        if (state_reg == ST_DIVGO)
            neg_reg <= mul_reg[50];
        if (state_reg == ST_WRITE)
        begin
            if (dv > maxc_reg)
                maxc_reg <= dv;
            tl_reg <= ti_reg;
            ti_reg <= tr_reg;
        end
        if (state_reg == ST_RDB)
            inner_q_reg <= rd_q_reg;
        if (state_reg == ST_RDN)
            iface_q_reg <= rd_q_reg;
        if (state_reg == ST_RDX)
            outer_q_reg <= rd_q_reg;
        if (state_reg == ST_FIN)
        begin
            res_reg.max_change      <= maxc_reg;
            res_reg.converged       <= (req_reg.req_type == rhd_pkg::REQ_STEP)
                                       && (maxc_reg < thr_reg);
            res_reg.inner_face_temp <= inner_q_reg;
            res_reg.interface_temp  <= iface_q_reg;
            res_reg.outer_face_temp <= outer_q_reg;
            res_reg.read_temp       <= ((req_reg.req_type == rhd_pkg::REQ_READ) && idx_ok)
                                       ? rd_q_reg : 32'd0;
            res_reg.steps_done      <= steps_reg;
        end
    end

    assign busy      = state_reg != ST_IDLE;
    assign done      = done_reg;
    assign result    = res_reg;
    assign cfg_ready = 1'b1;

    // The result strobe comes only once the sequencer is back at rest.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // An accepted item makes the block busy.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("item accepted but block not busy");

    // A converged result always carries a change below the threshold.
    a_conv: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.converged |-> result.max_change < thr_reg)
        else $error("converged flag with large change");

    // The divider only reports back while the sequencer waits for it.
    a_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIVW)
        else $error("divider done outside wait state");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = 512;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    rhd_pkg::req_t req = '0;
    logic          done;
    rhd_pkg::res_t result;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [2:0]    cfg_index = '0;
    logic [31:0]   cfg_data = '0;

    radial_heat_diffusion_step #(.MAX_NODES(NODES)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // Shadow copy of the wall profile and of the registers.
    logic [31:0] wall_temp [NODES];
    logic [31:0] step_count;
    logic [8:0]  seg_reg;
    logic [8:0]  iface_reg;
    logic [14:0] gain_in_reg;
    logic [14:0] gain_out_reg;
    logic [15:0] radius_reg;
    logic [15:0] w_in_reg;
    logic [15:0] w_out_reg;
    logic [31:0] thresh_reg;

    rhd_pkg::res_t pending_results [$];
    int   error_count = 0;
    int   gap_max = 19;

    function automatic logic [31:0] face_blend(logic [15:0] w, logic [31:0] target,
                                               logic [31:0] t);
        longint unsigned s;
        s = longint'(w) * target + (longint'(65536) - w) * t + 32768;
        return s[47:16];
    endfunction

    function automatic logic [31:0] conduct(logic [31:0] tl, logic [31:0] ti,
                                            logic [31:0] tr, logic [14:0] g, int i);
        longint lap, den, curv, v;
        lap  = longint'(tl) + longint'(tr) - 2 * longint'(ti);
        den  = longint'(radius_reg) + 16 * i;
        curv = (longint'(g) * (longint'(tr) - longint'(tl)) * 8) / den;
        v    = longint'(ti) + ((longint'(g) * lap + curv + 32768) >>> 16);
        if (v < 0)
            v = 0;
        if (v > 64'hFFFF_FFFF)
            v = 64'hFFFF_FFFF;
        return v[31:0];
    endfunction

    function automatic void fill_wall();
        for (int i = 0; i < NODES; i++)
            wall_temp[i] = rhd_pkg::TEMP_INIT;
        step_count = '0;
    endfunction

    // Works out the result of one request and advances the shadow state.
    function automatic rhd_pkg::res_t predict_request(rhd_pkg::req_t r);
        logic [31:0]   next_temp [NODES];
        logic [31:0]   dv;
        rhd_pkg::res_t o;
        int            n, b;
        n = (seg_reg < 2) ? 2 : int'(seg_reg);
        if (n > NODES - 1)
            n = NODES - 1;
        b = (iface_reg < 1) ? 1 : int'(iface_reg);
        if (b > n - 1)
            b = n - 1;
        o = '0;
        if (r.req_type == rhd_pkg::REQ_INIT)
        begin
            fill_wall();
        end
        else if (r.req_type == rhd_pkg::REQ_STEP)
        begin
            next_temp = wall_temp;
            next_temp[0] = face_blend(w_in_reg, rhd_pkg::TEMP_HOT, wall_temp[1]);
            for (int i = 1; i < n; i++)
            begin
                if (i == b)
                    next_temp[i] = 32'((64'd15 * wall_temp[i-1] + wall_temp[i+1] + 8) >> 4);
                else
                    next_temp[i] = conduct(wall_temp[i-1], wall_temp[i], wall_temp[i+1],
                                           (i < b) ? gain_in_reg : gain_out_reg, i);
            end
            next_temp[n] = face_blend(w_out_reg, rhd_pkg::TEMP_AMB, wall_temp[n-1]);
            for (int i = 0; i <= n; i++)
            begin
                dv = (next_temp[i] > wall_temp[i]) ? next_temp[i] - wall_temp[i]
                                                   : wall_temp[i] - next_temp[i];
                if (dv > o.max_change)
                    o.max_change = dv;
            end
            wall_temp = next_temp;
            step_count++;
            o.converged = o.max_change < thresh_reg;
        end
        else if (r.req_type == rhd_pkg::REQ_READ)
        begin
            o.read_temp = wall_temp[r.node_index];
        end
        o.inner_face_temp = wall_temp[0];
        o.interface_temp  = wall_temp[b];
        o.outer_face_temp = wall_temp[n];
        o.steps_done      = step_count;
        return o;
    endfunction

    // Drives one register write; the caller drops cfg_valid after the last one.
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            rhd_pkg::CFG_SEGMENTS:  seg_reg      = data[8:0];
            rhd_pkg::CFG_IFACE:     iface_reg    = data[8:0];
            rhd_pkg::CFG_GAIN_IN:   gain_in_reg  = data[14:0];
            rhd_pkg::CFG_GAIN_OUT:  gain_out_reg = data[14:0];
            rhd_pkg::CFG_RADIUS:    radius_reg   = data[15:0];
            rhd_pkg::CFG_W_INNER:   w_in_reg     = data[15:0];
            rhd_pkg::CFG_W_OUTER:   w_out_reg    = data[15:0];
            default:                thresh_reg   = data;
        endcase
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Sends one item; the expectation is either the predicted one or a literal.
    task automatic send_item(rhd_pkg::req_t r, bit use_literal, rhd_pkg::res_t literal);
        int            gap;
        rhd_pkg::res_t predicted;
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
        predicted = predict_request(r);
        pending_results.push_back(use_literal ? literal : predicted);
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        rhd_pkg::res_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no item outstanding");
                error_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("max_change", e.max_change, result.max_change);
                check_field("converged", 32'(e.converged), 32'(result.converged));
                check_field("inner_face_temp", e.inner_face_temp, result.inner_face_temp);
                check_field("interface_temp", e.interface_temp, result.interface_temp);
                check_field("outer_face_temp", e.outer_face_temp, result.outer_face_temp);
                check_field("read_temp", e.read_temp, result.read_temp);
                check_field("steps_done", e.steps_done, result.steps_done);
            end
        end
    end

    typedef struct {
        int            phase;
        rhd_pkg::req_t r;
        bit            lit;
        rhd_pkg::res_t exp_res;
    } stim_row_t;

    localparam rhd_pkg::res_t AT_REST = '{32'd0, 1'b0, rhd_pkg::TEMP_INIT,
                                          rhd_pkg::TEMP_INIT, rhd_pkg::TEMP_INIT,
                                          rhd_pkg::TEMP_INIT, 32'd0};
    localparam rhd_pkg::res_t FRESH   = '{32'd0, 1'b0, rhd_pkg::TEMP_INIT,
                                          rhd_pkg::TEMP_INIT, rhd_pkg::TEMP_INIT,
                                          32'd0, 32'd0};

    // Register sets for the directed phases; phase 0 keeps the reset values.
    logic [31:0] phase_regs [4][8] = '{
        '{300, 100, 10518, 17476, 1600, 2621, 806, 10},
        '{0, 0, 32'h7FFF, 32'h7FFF, 0, 32'hFFFF, 0, 32'hFFFF_FFFF},
        '{511, 510, 0, 0, 32'hFFFF, 0, 32'hFFFF, 0},
        '{10, 300, 1234, 30000, 16, 40000, 20000, 32'h0010_0000}
    };

    stim_row_t directed [] = '{
        '{0, '{rhd_pkg::REQ_READ, 9'd0},   1, AT_REST},
        '{0, '{rhd_pkg::REQ_READ, 9'd511}, 1, AT_REST},
        '{0, '{rhd_pkg::REQ_NOP, 9'd7},    1, FRESH},
        '{0, '{rhd_pkg::REQ_STEP, 9'd0},   0, FRESH},
        '{0, '{rhd_pkg::REQ_STEP, 9'd300}, 0, FRESH},
        '{0, '{rhd_pkg::REQ_READ, 9'd1},   0, FRESH},
        '{0, '{rhd_pkg::REQ_READ, 9'd300}, 0, FRESH},
        '{0, '{rhd_pkg::REQ_READ, 9'd400}, 0, FRESH},
        '{0, '{rhd_pkg::REQ_INIT, 9'd5},   1, FRESH},
        '{1, '{rhd_pkg::REQ_STEP, 9'd0},   0, FRESH},
        '{1, '{rhd_pkg::REQ_STEP, 9'd0},   0, FRESH},
        '{1, '{rhd_pkg::REQ_READ, 9'd1},   0, FRESH},
        '{1, '{rhd_pkg::REQ_READ, 9'd2},   0, FRESH},
        '{1, '{rhd_pkg::REQ_READ, 9'd3},   0, FRESH},
        '{1, '{rhd_pkg::REQ_STEP, 9'd0},   0, FRESH},
        '{2, '{rhd_pkg::REQ_STEP, 9'd0},   0, FRESH},
        '{2, '{rhd_pkg::REQ_READ, 9'd510}, 0, FRESH},
        '{2, '{rhd_pkg::REQ_READ, 9'd511}, 0, FRESH},
        '{3, '{rhd_pkg::REQ_STEP, 9'd0},   0, FRESH},
        '{3, '{rhd_pkg::REQ_STEP, 9'd0},   0, FRESH},
        '{3, '{rhd_pkg::REQ_STEP, 9'd0},   0, FRESH},
        '{3, '{rhd_pkg::REQ_READ, 9'd9},   0, FRESH},
        '{3, '{rhd_pkg::REQ_NOP, 9'd511},  0, FRESH}
    };

    // Main sequence: directed table, then random register sets and requests.
    initial
    begin
        int            phase_now;
        rhd_pkg::req_t r;
        int            pick;
        logic [31:0]   regs [8];
        seg_reg = 300; iface_reg = 100; gain_in_reg = 10518; gain_out_reg = 17476;
        radius_reg = 1600; w_in_reg = 2621; w_out_reg = 806; thresh_reg = 10;
        fill_wall();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        phase_now = 0;
        foreach (directed[k])
        begin
            if (directed[k].phase != phase_now)
            begin
                start <= 1'b0;
                wait_idle();
                phase_now = directed[k].phase;
                for (int j = 0; j < 8; j++)
                    write_reg(j[2:0], phase_regs[phase_now][j]);
                cfg_valid <= 1'b0;
            end
            send_item(directed[k].r, directed[k].lit, directed[k].exp_res);
        end

        for (int p = 0; p < 10; p++)
        begin
            start <= 1'b0;
            wait_idle();
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
            regs[0] = ($urandom & ~32'h1FF) | $urandom_range(2, 40);
            if (p == 9)
                regs[0] = 32'd200;
            regs[1] = ($urandom & ~32'h1FF) | $urandom_range(0, 45);
            regs[2] = (p == 3) ? 32'h7FFF : $urandom;
            regs[3] = (p == 3) ? 32'h0 : $urandom;
            regs[4] = $urandom;
            regs[5] = $urandom;
            regs[6] = $urandom;
            regs[7] = (p % 2) ? $urandom : $urandom_range(0, 32'h0040_0000);
            for (int j = 0; j < 8; j++)
                write_reg(j[2:0], regs[j]);
            cfg_valid <= 1'b0;
            for (int k = 0; k < 27; k++)
            begin
                pick = $urandom_range(0, 99);
                r.node_index = $urandom_range(0, 511);
                if (pick < 8)
                    r.req_type = rhd_pkg::REQ_INIT;
                else if (pick < 68)
                    r.req_type = rhd_pkg::REQ_STEP;
                else if (pick < 95)
                    r.req_type = rhd_pkg::REQ_READ;
                else
                    r.req_type = rhd_pkg::REQ_NOP;
                send_item(r, 1'b0, FRESH);
            end
        end
        start <= 1'b0;
        wait_idle();
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Run limit.
    initial
    begin
        #100ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

FILE: radial_heat_diffusion_step.f
design/rhd_pkg.sv
design/rhd_div.sv
design/radial_heat_diffusion_step.sv
bench/testbench.sv
